// ===== rtl/core/pde_pkg.sv =====
// shared types and constants for the playfair digraph encryptor
package pde_pkg;

    typedef enum logic [1:0] {
        CMD_KEY_BYTE = 2'd0,
        CMD_KEY_END  = 2'd1,
        CMD_MSG_BYTE = 2'd2,
        CMD_MSG_END  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_KEY_LETTER = 2'd0,
        OP_KEY_END    = 2'd1,
        OP_MSG_LETTER = 2'd2,
        OP_MSG_END    = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] code;
    } op_entry_t;

    localparam logic [4:0] CELLS    = 5'd25;
    localparam logic [4:0] LAST_CODE = 5'd25;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [6:0] ASCII_A  = 7'd65;

endpackage

// ===== rtl/core/pde_ram.sv =====
// generic ram, one write port and two registered read ports
module pde_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/pde_front.sv =====
// input side: folds case, drops non-letters and j, turns commands into queue entries
module pde_front import pde_pkg::*; (
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    input  logic        q_full,
    output logic        q_push,
    output op_entry_t   q_entry
);

    logic       is_letter;
    logic [4:0] code;
    logic [7:0] upper_off;
    logic [7:0] lower_off;
    logic       keep;
    cmd_t       cmd;

    assign cmd       = cmd_t'(s_axis_tuser);
    assign upper_off = s_axis_tdata - 8'd65;
    assign lower_off = s_axis_tdata - 8'd97;

    always_comb
    begin
        is_letter = 1'b0;
        code      = 5'd0;
        if (s_axis_tdata >= 8'd65 && s_axis_tdata <= 8'd90)
        begin
            is_letter = 1'b1;
            code      = upper_off[4:0];
        end
        else if (s_axis_tdata >= 8'd97 && s_axis_tdata <= 8'd122)
        begin
            is_letter = 1'b1;
            code      = lower_off[4:0];
        end
    end

    always_comb
    begin
        keep          = 1'b0;
        q_entry.code  = code;
        q_entry.op    = OP_KEY_LETTER;
        unique case (cmd)
            CMD_KEY_BYTE:
            begin
                keep       = is_letter && (code != LETTER_J);
                q_entry.op = OP_KEY_LETTER;
            end
            CMD_KEY_END:
            begin
                keep       = 1'b1;
                q_entry.op = OP_KEY_END;
            end
            CMD_MSG_BYTE:
            begin
                keep       = is_letter && (code != LETTER_J);
                q_entry.op = OP_MSG_LETTER;
            end
            CMD_MSG_END:
            begin
                keep       = 1'b1;
                q_entry.op = OP_MSG_END;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full && keep;

endmodule

// ===== rtl/core/pde_queue.sv =====
// two-entry queue between the front and the back
module pde_queue import pde_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_entry_t push_entry,
    input  logic      pop,
    output op_entry_t head,
    output logic      empty,
    output logic      full,
    output logic [1:0] level
);

    op_entry_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign level   = count_reg;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/pde_back.sv =====
// execution side: builds the square, pairs letters and encrypts digraphs
module pde_back import pde_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  op_entry_t  q_head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,   // first_letter[6:0], second_letter[13:7], zero pad
    output logic [4:0] fill_count
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_POS  = 5'b00100,
        ST_CELL = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  fill_reg, fill_next;
    logic [25:0] present_reg, present_next;
    logic [4:0]  pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [4:0]  cursor_reg, cursor_next;
    logic [4:0]  walk_reg, walk_next;
    logic        in0_reg, in1_reg;
    logic [6:0]  res0_reg, res1_reg;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  out0_reg, out1_reg;

    logic        place_en;
    logic [4:0]  place_code;
    logic [4:0]  b_code;
    logic [4:0]  filler;
    logic [4:0]  cursor_after;
    logic [4:0]  pos_a, pos_b;
    logic [4:0]  cell_a, cell_b;
    logic [4:0]  idx0, idx1;
    logic        load_out;

    function automatic logic [4:0] inc26(input logic [4:0] c);
        return (c == LAST_CODE) ? 5'd0 : c + 5'd1;
    endfunction

    function automatic logic [2:0] inc5(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        priority if (p < 5'd5)  r = 3'd0;
        else if (p < 5'd10)     r = 3'd1;
        else if (p < 5'd15)     r = 3'd2;
        else if (p < 5'd20)     r = 3'd3;
        else                    r = 3'd4;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [4:0] d;
        d = p - cell_idx(pos_row(p), 3'd0);
        return d[2:0];
    endfunction

    // filler: skip j and the doubled letter, then step the cursor past it
    always_comb
    begin
        logic [4:0] c;
        logic [4:0] n;
        c = cursor_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (c == pend_reg || c == LETTER_J)
            begin
                c = inc26(c);
            end
        end
        n = inc26(c);
        if (n == LETTER_J)
        begin
            n = n + 5'd1;
        end
        filler       = c;
        cursor_after = n;
    end

    // digraph rules on the two positions
    always_comb
    begin
        logic [2:0] ar, ac, br, bc;
        ar = pos_row(pos_a);
        ac = pos_col(pos_a);
        br = pos_row(pos_b);
        bc = pos_col(pos_b);
        if (ar == br)
        begin
            idx0 = cell_idx(ar, inc5(ac));
            idx1 = cell_idx(br, inc5(bc));
        end
        else if (ac == bc)
        begin
            idx0 = cell_idx(inc5(ar), ac);
            idx1 = cell_idx(inc5(br), bc);
        end
        else
        begin
            idx0 = cell_idx(ar, bc);
            idx1 = cell_idx(br, ac);
        end
    end

    pde_ram #(.WIDTH(5), .DEPTH(26)) u_pos_ram (
        .clk       (clk),
        .wr_en     (place_en),
        .wr_addr   (place_code),
        .wr_data   (fill_reg),
        .rd_addr_a (pend_reg),
        .rd_addr_b (b_code),
        .rd_data_a (pos_a),
        .rd_data_b (pos_b)
    );

    pde_ram #(.WIDTH(5), .DEPTH(25)) u_cell_ram (
        .clk       (clk),
        .wr_en     (place_en),
        .wr_addr   (fill_reg),
        .wr_data   (place_code),
        .rd_addr_a (idx0),
        .rd_addr_b (idx1),
        .rd_data_a (cell_a),
        .rd_data_b (cell_b)
    );

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        present_next    = present_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cursor_next     = cursor_reg;
        walk_next       = walk_reg;
        place_en        = 1'b0;
        place_code      = q_head.code;
        b_code          = q_head.code;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.op)
                        OP_KEY_LETTER:
                        begin
                            place_en = !present_reg[q_head.code] && (fill_reg < CELLS);
                        end
                        OP_KEY_END:
                        begin
                            walk_next  = 5'd0;
                            state_next = ST_WALK;
                        end
                        OP_MSG_LETTER:
                        begin
                            if (!pend_valid_reg)
                            begin
                                pend_next       = q_head.code;
                                pend_valid_next = 1'b1;
                            end
                            else if (pend_reg != q_head.code)
                            begin
                                pend_valid_next = 1'b0;
                                state_next      = ST_POS;
                            end
                            else
                            begin
                                b_code      = filler;
                                cursor_next = cursor_after;
                                state_next  = ST_POS;
                            end
                        end
                        OP_MSG_END:
                        begin
                            cursor_next = 5'd0;
                            if (pend_valid_reg)
                            begin
                                b_code          = filler;
                                pend_valid_next = 1'b0;
                                state_next      = ST_POS;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                place_code = walk_reg;
                place_en   = !present_reg[walk_reg] && (walk_reg != LETTER_J)
                             && (fill_reg < CELLS);
                if (walk_reg == LAST_CODE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + 5'd1;
                end
            end
            ST_POS:
            begin
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (place_en)
        begin
            present_next[place_code] = 1'b1;
            fill_next                = fill_reg + 5'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 5'd0;
            present_reg    <= '0;
            pend_reg       <= 5'd0;
            pend_valid_reg <= 1'b0;
            cursor_reg     <= 5'd0;
            walk_reg       <= 5'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            present_reg    <= present_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            cursor_reg     <= cursor_next;
            walk_reg       <= walk_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // empty cells read as letter a
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POS)
        begin
            in0_reg <= (idx0 < fill_reg);
            in1_reg <= (idx1 < fill_reg);
        end
        if (state_reg == ST_CELL)
        begin
            res0_reg <= ASCII_A + (in0_reg ? {2'b00, cell_a} : 7'd0);
            res1_reg <= ASCII_A + (in1_reg ? {2'b00, cell_b} : 7'd0);
        end
        if (load_out)
        begin
            out0_reg <= res0_reg;
            out1_reg <= res1_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out1_reg, out0_reg};
    assign fill_count    = fill_reg;

endmodule

// ===== rtl/core/playfair_digraph_encryptor.sv =====
// top level of the playfair digraph encryptor
// Bytes arrive on the slave stream with the command in tuser; each completed digraph leaves
// on the master stream as two upper-case ascii letters. The front classifies a byte in the
// transfer cycle and parks it in a two-entry queue, so input keeps flowing while the back is
// busy or a result waits, until the queue is full. The back handles a key letter, a message
// letter that opens a digraph or a dropped command without leaving idle, walks every letter
// of the alphabet for key end, and for an encrypted digraph reads the position ram, reads
// the cell ram, forms the letters and loads the output register once it is free.
// Letters outside a-z and the letter j are dropped in the front.
module playfair_digraph_encryptor import pde_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // first_letter[6:0], second_letter[13:7], zero pad
);

    op_entry_t  push_entry;
    op_entry_t  head;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic [1:0] q_level;
    logic [4:0] fill_count;

    pde_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    pde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full),
        .level      (q_level)
    );

    pde_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (head),
        .q_empty       (q_empty),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fill_count    (fill_count)
    );

    // square never overfills
    assert property (@(posedge clk) disable iff (!rst_n) fill_count <= CELLS)
        else $error("square fill count beyond 25 cells");

    // cells are only ever added
    assert property (@(posedge clk) disable iff (!rst_n) fill_count >= $past(fill_count))
        else $error("square fill count went down");

    // queue level stays in range and matches the ready it shows
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_level <= 2'd2) && (s_axis_tready == (q_level != 2'd2)))
        else $error("queue level out of step with input ready");

endmodule
